@@ hw/rtl/tcp_cw_rto_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_cw_rto_pkg
// types and constants shared by the congestion window and rto core and its
// checker
// ----------------------------------------------------------------------------
package tcp_cw_rto_pkg;

    // field widths
    localparam int unsigned WinW     = 16;
    localparam int unsigned AckW     = 32;
    localparam int unsigned SeqW     = 31;
    localparam int unsigned RttW     = 20;
    localparam int unsigned EstW     = 24;
    localparam int unsigned DupW     = 8;
    localparam int unsigned BackoffW = 5;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 24;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_INITIAL_SSTHRESH = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_DUP_ACK_LIMIT    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_RTO_BOUND_MS     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_BACKOFF_FACTOR   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_INITIAL_RTO_MS   = 3'd4;

    // register reset values
    localparam logic [WinW-1:0]     RST_INITIAL_SSTHRESH = 16'd64;
    localparam logic [DupW-1:0]     RST_DUP_ACK_LIMIT    = 8'd3;
    localparam logic [EstW-1:0]     RST_RTO_BOUND_MS     = 24'd240000;
    localparam logic [BackoffW-1:0] RST_BACKOFF_FACTOR   = 5'd1;
    localparam logic [EstW-1:0]     RST_INITIAL_RTO_MS   = 24'd3000;

    // estimator reset, 10 ms in q3
    localparam logic [EstW-1:0] RST_EST_Q3 = 24'd80;

    // command codes
    localparam logic CMD_ACK     = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    localparam logic [AckW-1:0] DONE_MARK = '1;
    localparam logic [WinW-1:0] MIN_SSTHRESH = 16'd2;

    typedef struct packed {
        logic                   command;
        logic signed [AckW-1:0] ack_number;
        logic [RttW-1:0]        rtt_sample_ms;
    } in_word_t;

    typedef struct packed {
        logic [WinW-1:0] window_packets;
        logic [WinW-1:0] slow_start_threshold;
        logic [EstW-1:0] timeout_ms;
        logic            retransmit;
        logic [SeqW-1:0] retransmit_seq;
        logic            transfer_done;
    } out_word_t;

endpackage
`default_nettype wire

@@ hw/rtl/tcp_congestion_window_and_rto_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_congestion_window_and_rto_core
// reno style congestion window with a jacobson retransmission timeout
// ----------------------------------------------------------------------------
//  channel   ports                     direction  handshake
//  event     s_valid s_ready s_data    in         valid / ready, in_word_t
//  result    m_valid m_ready m_data    out        valid / ready, out_word_t
//  config    cfg_wr_en cfg_index cfg_data  in     write strobe, no wait
//
//  one word per cycle sustained while m_ready stays high; a word moves from the
//  input register into the result register once that register is free or emptied
//  the whole state update (estimators, timeout product, window) is combinational
//  between the input register and the result register
//  the result register stalls on m_ready low; the input register takes a new
//  word while the held result waits, so one further word can queue
//  aresetn is synchronous and active low; it loads the register defaults
// ----------------------------------------------------------------------------
module tcp_congestion_window_and_rto_core (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      s_valid,
    output logic                                           s_ready,
    input  wire tcp_cw_rto_pkg::in_word_t                  s_data,
    output logic                                           m_valid,
    input  wire logic                                      m_ready,
    output tcp_cw_rto_pkg::out_word_t                      m_data,
    input  wire logic                                      cfg_wr_en,
    input  wire logic [tcp_cw_rto_pkg::CfgIdxW-1:0]        cfg_index,
    input  wire logic [tcp_cw_rto_pkg::CfgDataW-1:0]       cfg_data
);

    localparam int unsigned WinW     = tcp_cw_rto_pkg::WinW;
    localparam int unsigned SeqW     = tcp_cw_rto_pkg::SeqW;
    localparam int unsigned AckW     = tcp_cw_rto_pkg::AckW;
    localparam int unsigned EstW     = tcp_cw_rto_pkg::EstW;
    localparam int unsigned DupW     = tcp_cw_rto_pkg::DupW;
    localparam int unsigned BackoffW = tcp_cw_rto_pkg::BackoffW;
    localparam int unsigned SumW     = EstW + 3;          // est + 4 * dev
    localparam int unsigned ProdW    = SumW + BackoffW;   // backoff * sum

    // configuration registers
    logic [DupW-1:0]     dup_limit_cfg_reg;
    logic [EstW-1:0]     rto_bound_cfg_reg;
    logic [BackoffW-1:0] backoff_cfg_reg;

    // input register
    logic                     in_valid_reg;
    tcp_cw_rto_pkg::in_word_t in_word_reg;

    // result register
    logic                      out_valid_reg;
    tcp_cw_rto_pkg::out_word_t out_word_reg;
    tcp_cw_rto_pkg::out_word_t out_word_next;

    // congestion state
    logic [WinW-1:0] window_reg,    window_next;
    logic [WinW-1:0] thresh_reg,    thresh_next;
    logic [WinW-1:0] avoid_cnt_reg, avoid_cnt_next;
    logic [DupW-1:0] dup_cnt_reg,   dup_cnt_next;
    logic [AckW-1:0] prev_ack_reg,  prev_ack_next;
    logic [SeqW-1:0] base_seq_reg,  base_seq_next;
    logic [EstW-1:0] srtt_reg,      srtt_next;
    logic [EstW-1:0] rttvar_reg,    rttvar_next;
    logic [EstW-1:0] rto_reg,       rto_next;

    logic advance;

    // the input register drains whenever the result register is free or
    // being emptied in the same cycle
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dup_limit_cfg_reg <= tcp_cw_rto_pkg::RST_DUP_ACK_LIMIT;
            rto_bound_cfg_reg <= tcp_cw_rto_pkg::RST_RTO_BOUND_MS;
            backoff_cfg_reg   <= tcp_cw_rto_pkg::RST_BACKOFF_FACTOR;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tcp_cw_rto_pkg::REG_DUP_ACK_LIMIT:    dup_limit_cfg_reg <= cfg_data[DupW-1:0];
                tcp_cw_rto_pkg::REG_RTO_BOUND_MS:     rto_bound_cfg_reg <= cfg_data[EstW-1:0];
                tcp_cw_rto_pkg::REG_BACKOFF_FACTOR:   backoff_cfg_reg   <= cfg_data[BackoffW-1:0];
                // initial threshold and timeout only reach the state at reset,
                // and reset brings them back to their defaults
                tcp_cw_rto_pkg::REG_INITIAL_SSTHRESH,
                tcp_cw_rto_pkg::REG_INITIAL_RTO_MS: ;
                default: ; // unused indexes are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // rtt estimators and timeout
    // ------------------------------------------------------------------
    logic [EstW-1:0]   sample_q3;
    logic [EstW+3:0]   srtt_acc;      // 7 * srtt + sample
    logic [EstW-1:0]   srtt_upd;
    logic [EstW-1:0]   rtt_diff;
    logic [EstW+2:0]   rttvar_acc;    // 3 * rttvar + diff
    logic [EstW-1:0]   rttvar_upd;
    logic [SumW-1:0]   rto_sum;
    logic [ProdW-1:0]  rto_prod;
    logic [ProdW-4:0]  rto_scaled;
    logic [EstW-1:0]   rto_upd;

    always_comb begin
        sample_q3  = {1'b0, in_word_reg.rtt_sample_ms, 3'b000};
        srtt_acc   = (EstW+4)'({srtt_reg, 3'b000}) - (EstW+4)'(srtt_reg)
                   + (EstW+4)'(sample_q3);
        // the divided sum always fits the estimator width
        srtt_upd   = srtt_acc[EstW+2:3];
        rtt_diff   = (sample_q3 >= srtt_upd) ? (sample_q3 - srtt_upd)
                                             : (srtt_upd - sample_q3);
        rttvar_acc = (EstW+3)'({rttvar_reg, 1'b0}) + (EstW+3)'(rttvar_reg)
                   + (EstW+3)'(rtt_diff);
        rttvar_upd = rttvar_acc[EstW+1:2];
        rto_sum    = SumW'(srtt_upd) + SumW'({rttvar_upd, 2'b00});
        rto_prod   = ProdW'(backoff_cfg_reg) * ProdW'(rto_sum);
        rto_scaled = rto_prod[ProdW-1:3];
        // saturate at the field maximum
        rto_upd    = (|rto_scaled[ProdW-4:EstW]) ? '1 : rto_scaled[EstW-1:0];
    end

    // ------------------------------------------------------------------
    // window, duplicate counting and result word
    // ------------------------------------------------------------------
    logic [WinW-1:0] half_window;
    logic [WinW-1:0] halved_thresh;
    logic [WinW-1:0] window_inc;
    logic [WinW-1:0] avoid_inc;
    logic [DupW-1:0] dup_inc;
    logic            ack_done;
    logic            ack_dup;
    logic            resend;

    always_comb begin
        half_window   = window_reg >> 1;
        halved_thresh = (half_window > tcp_cw_rto_pkg::MIN_SSTHRESH) ?
                        half_window : tcp_cw_rto_pkg::MIN_SSTHRESH;
        window_inc    = (&window_reg)  ? window_reg  : window_reg + 1'b1;
        avoid_inc     = (&avoid_cnt_reg) ? avoid_cnt_reg : avoid_cnt_reg + 1'b1;
        dup_inc       = (&dup_cnt_reg) ? dup_cnt_reg : dup_cnt_reg + 1'b1;
        ack_done      = (in_word_reg.ack_number == tcp_cw_rto_pkg::DONE_MARK);
        ack_dup       = (in_word_reg.ack_number == prev_ack_reg);

        window_next    = window_reg;
        thresh_next    = thresh_reg;
        avoid_cnt_next = avoid_cnt_reg;
        dup_cnt_next   = dup_cnt_reg;
        prev_ack_next  = prev_ack_reg;
        base_seq_next  = base_seq_reg;
        srtt_next      = srtt_reg;
        rttvar_next    = rttvar_reg;
        rto_next       = rto_reg;
        resend         = 1'b0;

        if (in_word_reg.command == tcp_cw_rto_pkg::CMD_TIMEOUT) begin
            thresh_next = halved_thresh;
            window_next = WinW'(1);
            resend      = 1'b1;
        end else begin
            // every ack, the completion mark included, feeds the estimators
            srtt_next   = srtt_upd;
            rttvar_next = rttvar_upd;
            if (rto_reg <= rto_bound_cfg_reg) begin
                rto_next = rto_upd;
            end
            if (ack_done) begin
                // completion mark touches nothing else
            end else if (ack_dup) begin
                if (dup_inc >= dup_limit_cfg_reg) begin
                    dup_cnt_next = '0;
                    resend       = 1'b1;
                    thresh_next  = halved_thresh;
                    window_next  = WinW'(1);
                end else begin
                    dup_cnt_next = dup_inc;
                end
            end else begin
                prev_ack_next = in_word_reg.ack_number;
                dup_cnt_next  = '0;
                base_seq_next = in_word_reg.ack_number[SeqW-1:0];
                if (window_reg <= thresh_reg) begin
                    // slow start
                    window_next = window_inc;
                end else if ({1'b0, avoid_inc} == ({1'b0, window_reg} + 1'b1)) begin
                    // congestion avoidance, one step per window + 1 acks
                    window_next    = window_inc;
                    avoid_cnt_next = '0;
                end else begin
                    avoid_cnt_next = avoid_inc;
                end
            end
        end

        out_word_next.window_packets       = window_next;
        out_word_next.slow_start_threshold = thresh_next;
        out_word_next.timeout_ms           = rto_next;
        out_word_next.retransmit           = resend;
        out_word_next.retransmit_seq       = resend ? base_seq_reg : '0;
        out_word_next.transfer_done        =
            (in_word_reg.command == tcp_cw_rto_pkg::CMD_ACK) && ack_done;
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= WinW'(1);
            thresh_reg    <= tcp_cw_rto_pkg::RST_INITIAL_SSTHRESH;
            avoid_cnt_reg <= '0;
            dup_cnt_reg   <= '0;
            prev_ack_reg  <= '0;
            base_seq_reg  <= '0;
            srtt_reg      <= tcp_cw_rto_pkg::RST_EST_Q3;
            rttvar_reg    <= tcp_cw_rto_pkg::RST_EST_Q3;
            rto_reg       <= tcp_cw_rto_pkg::RST_INITIAL_RTO_MS;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                window_reg    <= window_next;
                thresh_reg    <= thresh_next;
                avoid_cnt_reg <= avoid_cnt_next;
                dup_cnt_reg   <= dup_cnt_next;
                prev_ack_reg  <= prev_ack_next;
                base_seq_reg  <= base_seq_next;
                srtt_reg      <= srtt_next;
                rttvar_reg    <= rttvar_next;
                rto_reg       <= rto_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_data;
        end
        if (advance) begin
            out_word_reg <= out_word_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/tcp_cw_rto_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_cw_rto_checker
// port level checks on the result channel of the congestion core
// ----------------------------------------------------------------------------
module tcp_cw_rto_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire tcp_cw_rto_pkg::out_word_t m_data
);

    // a held result stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // window never collapses to zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.window_packets != '0)
        else $error("window of zero");

    // a retransmit always leaves window one and threshold at least two
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.retransmit |->
            m_data.window_packets == 16'd1 &&
            m_data.slow_start_threshold >= tcp_cw_rto_pkg::MIN_SSTHRESH)
        else $error("retransmit without halving");

    // completion and retransmit are exclusive; no sequence without resend
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.retransmit |->
            m_data.retransmit_seq == '0)
        else $error("sequence shown without retransmit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.transfer_done |-> !m_data.retransmit)
        else $error("retransmit on completion mark");

endmodule

bind tcp_congestion_window_and_rto_core tcp_cw_rto_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
